/* hdl/ledsu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package ledsu_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int QUEUE_DEPTH = 4;
	localparam int COUNT_WIDTH = 4;
	localparam int SUM_WIDTH = 64;
	localparam int DIST_WIDTH = 32;
	localparam int TOTAL_WIDTH = 48;
	localparam int STEP_WIDTH = 5;
	localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = '1;
	localparam logic [SUM_WIDTH-1:0] SUM_MAX = '1;

	typedef struct packed {
		logic [SUM_WIDTH-1:0] square_sum;
		logic                 last;
		logic                 sat;
	} point_t;

endpackage
`default_nettype wire

/* hdl/ledsu_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
module ledsu_queue (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            push,
	input  wire ledsu_pkg::point_t               push_entry,
	input  wire logic                            pop,
	output ledsu_pkg::point_t                    head,
	output logic                                 empty,
	output logic [ledsu_pkg::COUNT_WIDTH-1:0]    count
);
	import ledsu_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	point_t                 entry_q [QUEUE_DEPTH];
	logic [PW-1:0]          wr_q;
	logic [PW-1:0]          rd_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic                   do_pop;

	assign do_pop = pop && (count_q != '0);
	assign head   = entry_q[rd_q];
	assign empty  = (count_q == '0);
	assign count  = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + PW'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + COUNT_WIDTH'(1);
			end else if (!push && do_pop) begin
				count_q <= count_q - COUNT_WIDTH'(1);
			end
		end
	end

endmodule
`default_nettype wire

/* hdl/ledsu_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module ledsu_front #(
	parameter int VALUE_WIDTH = ledsu_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic signed [31:0]              first_value,
	input  wire logic signed [31:0]              second_value,
	input  wire logic                            point_end,
	input  wire logic                            series_end,
	input  wire logic                            push,
	output logic                                 full,
	input  wire logic [ledsu_pkg::COUNT_WIDTH-1:0] queue_count,
	output logic                                 queue_push,
	output ledsu_pkg::point_t                    queue_entry
);
	import ledsu_pkg::*;

	logic                         accept;
	logic [32:0]                  a_ext;
	logic [32:0]                  b_ext;
	logic [32:0]                  diff;
	logic [32:0]                  diff_abs;
	logic [SUM_WIDTH:0]           sum_wide;
	logic [SUM_WIDTH-1:0]         sum_new;
	logic                         sat_new;
	logic [COUNT_WIDTH-1:0]       pending;

	logic                         valid_s1;
	logic [VALUE_WIDTH-1:0]       mag_s1;
	logic                         pe_s1;
	logic                         se_s1;
	logic                         valid_s2;
	logic [2*VALUE_WIDTH-1:0]     sq_s2;
	logic                         pe_s2;
	logic                         se_s2;
	logic [SUM_WIDTH-1:0]         square_sum_q;
	logic                         sat_q;

	assign pending = queue_count
		+ COUNT_WIDTH'(valid_s1 && pe_s1)
		+ COUNT_WIDTH'(valid_s2 && pe_s2);
	assign full   = (pending >= COUNT_WIDTH'(QUEUE_DEPTH));
	assign accept = push && !full;

	assign a_ext    = {{(33-VALUE_WIDTH){first_value[VALUE_WIDTH-1]}},
		first_value[VALUE_WIDTH-1:0]};
	assign b_ext    = {{(33-VALUE_WIDTH){second_value[VALUE_WIDTH-1]}},
		second_value[VALUE_WIDTH-1:0]};
	assign diff     = a_ext - b_ext;
	assign diff_abs = diff[32] ? (33'd0 - diff) : diff;

	assign sum_wide = {1'b0, square_sum_q} + (SUM_WIDTH+1)'(sq_s2);
	assign sum_new  = sum_wide[SUM_WIDTH] ? SUM_MAX : sum_wide[SUM_WIDTH-1:0];
	assign sat_new  = sat_q || sum_wide[SUM_WIDTH];

	assign queue_push             = valid_s2 && pe_s2;
	assign queue_entry.square_sum = sum_new;
	assign queue_entry.last       = se_s2;
	assign queue_entry.sat        = sat_new;

	always_ff @(posedge clk) begin
		mag_s1 <= diff_abs[VALUE_WIDTH-1:0];
		pe_s1  <= point_end;
		se_s1  <= series_end;
		sq_s2  <= mag_s1 * mag_s1;
		pe_s2  <= pe_s1;
		se_s2  <= se_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			square_sum_q <= '0;
			sat_q        <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			if (valid_s2) begin
				if (pe_s2) begin
					square_sum_q <= '0;
					sat_q        <= se_s2 ? 1'b0 : sat_new;
				end else begin
					square_sum_q <= sum_new;
					sat_q        <= sat_new;
				end
			end
		end
	end

endmodule
`default_nettype wire

/* hdl/ledsu_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module ledsu_back (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire ledsu_pkg::point_t                   head,
	input  wire logic                                queue_empty,
	output logic                                     queue_pop,
	output logic [ledsu_pkg::DIST_WIDTH-1:0]         point_distance,
	output logic [ledsu_pkg::TOTAL_WIDTH-1:0]        running_total,
	output logic                                     series_last,
	output logic                                     overflow,
	output logic                                     empty,
	input  wire logic                                pop
);
	import ledsu_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROOT,
		ST_SUM
	} state_t;

	state_t                  state_q;
	logic [SUM_WIDTH-1:0]    rem_q;
	logic [SUM_WIDTH-1:0]    root_q;
	logic [STEP_WIDTH-1:0]   step_q;
	logic                    last_q;
	logic                    fsat_q;
	logic [TOTAL_WIDTH-1:0]  total_q;
	logic                    bsat_q;
	logic                    out_valid_q;
	logic [DIST_WIDTH-1:0]   dist_q;
	logic [TOTAL_WIDTH-1:0]  out_total_q;
	logic                    out_last_q;
	logic                    out_sat_q;

	logic [SUM_WIDTH-1:0]    bit_val;
	logic [SUM_WIDTH-1:0]    trial;
	logic [TOTAL_WIDTH:0]    total_wide;
	logic                    total_ovf;
	logic                    out_free;

	assign bit_val    = SUM_WIDTH'(1) << {step_q, 1'b0};
	assign trial      = root_q + bit_val;
	assign total_wide = {1'b0, total_q} + (TOTAL_WIDTH+1)'(root_q[DIST_WIDTH-1:0]);
	assign total_ovf  = total_wide[TOTAL_WIDTH];
	assign out_free   = !out_valid_q || pop;
	assign queue_pop  = (state_q == ST_IDLE) && !queue_empty;

	assign point_distance = dist_q;
	assign running_total  = out_total_q;
	assign series_last    = out_last_q;
	assign overflow       = out_sat_q;
	assign empty          = !out_valid_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_SUM && out_free) begin
			dist_q      <= root_q[DIST_WIDTH-1:0];
			out_total_q <= total_ovf ? TOTAL_MAX : total_wide[TOTAL_WIDTH-1:0];
			out_last_q  <= last_q;
			out_sat_q   <= fsat_q || bsat_q || total_ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rem_q       <= '0;
			root_q      <= '0;
			step_q      <= '0;
			last_q      <= 1'b0;
			fsat_q      <= 1'b0;
			total_q     <= '0;
			bsat_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_SUM && out_free) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!queue_empty) begin
						rem_q   <= head.square_sum;
						root_q  <= '0;
						step_q  <= '1;
						last_q  <= head.last;
						fsat_q  <= head.sat;
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (rem_q >= trial) begin
						rem_q  <= rem_q - trial;
						root_q <= (root_q >> 1) + bit_val;
					end else begin
						root_q <= root_q >> 1;
					end
					step_q <= step_q - STEP_WIDTH'(1);
					if (step_q == '0) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					if (out_free) begin
						if (last_q) begin
							total_q <= '0;
							bsat_q  <= 1'b0;
						end else begin
							total_q <= total_ovf ? TOTAL_MAX : total_wide[TOTAL_WIDTH-1:0];
							bsat_q  <= bsat_q || total_ovf;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* hdl/lockstep_euclidean_distance_sum_unit.sv */
// Lock-step Euclidean distance sum unit.
// Input channel: push/full. Each transaction carries one attribute pair
// (first_value, second_value, signed Q16.16) with point_end and series_end.
// Result channel: empty/pop. One result per transaction with point_end set:
// point_distance (Q16.16), running_total (Q32.16, saturating), series_last
// and overflow. Transactions without point_end produce no result.
// Attribute pairs are taken one per cycle while full is low; a two-stage
// front pipe squares and accumulates, then hands each finished point to a
// four-entry queue. The back end loads each point from the queue, runs the
// bit-serial square root (one result bit per cycle), then adds the total.
// The square root loop sets the pace: the back end takes a new point only
// once the last is done; attribute pairs in between flow at one per cycle while the queue has room.
// full rises when the queue plus points still in the front pipe fill it.
// A stalled receiver holds the result register; the back end finishes the
// next point and waits, and the queue then fills and raises full.
// Reset clears all sums, the total, the overflow history and the queue.
`timescale 1ns / 1ps
`default_nettype none
module lockstep_euclidean_distance_sum_unit #(
	parameter int VALUE_WIDTH = ledsu_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic signed [31:0]                 first_value,
	input  wire logic signed [31:0]                 second_value,
	input  wire logic                               point_end,
	input  wire logic                               series_end,
	input  wire logic                               push,
	output logic                                    full,
	output logic [ledsu_pkg::DIST_WIDTH-1:0]        point_distance,
	output logic [ledsu_pkg::TOTAL_WIDTH-1:0]       running_total,
	output logic                                    series_last,
	output logic                                    overflow,
	output logic                                    empty,
	input  wire logic                               pop
);
	import ledsu_pkg::*;

	logic                   q_push;
	point_t                 q_entry;
	logic                   q_pop;
	point_t                 q_head;
	logic                   q_empty;
	logic [COUNT_WIDTH-1:0] q_count;

	ledsu_front #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.first_value (first_value),
		.second_value(second_value),
		.point_end   (point_end),
		.series_end  (series_end),
		.push        (push),
		.full        (full),
		.queue_count (q_count),
		.queue_push  (q_push),
		.queue_entry (q_entry)
	);

	ledsu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_entry(q_entry),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty),
		.count     (q_count)
	);

	ledsu_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (q_head),
		.queue_empty   (q_empty),
		.queue_pop     (q_pop),
		.point_distance(point_distance),
		.running_total (running_total),
		.series_last   (series_last),
		.overflow      (overflow),
		.empty         (empty),
		.pop           (pop)
	);

endmodule
`default_nettype wire

/* tb/distance_sum_checker.sv */
`timescale 1ns / 1ps
module distance_sum_checker #(
	parameter int VALUE_WIDTH = ledsu_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic [31:0]                        first_value,
	input  wire logic [31:0]                        second_value,
	input  wire logic                               point_end,
	input  wire logic                               series_end,
	input  wire logic                               push,
	input  wire logic                               full,
	input  wire logic [ledsu_pkg::DIST_WIDTH-1:0]   point_distance,
	input  wire logic [ledsu_pkg::TOTAL_WIDTH-1:0]  running_total,
	input  wire logic                               series_last,
	input  wire logic                               overflow,
	input  wire logic                               empty,
	input  wire logic                               pop,
	output int                                      fail_count,
	output int                                      pending
);

	typedef struct {
		logic [ledsu_pkg::DIST_WIDTH-1:0]  distance;
		logic [ledsu_pkg::TOTAL_WIDTH-1:0] total;
		logic                              last;
		logic                              ovf;
	} point_result_t;

	point_result_t                     expected_points[$];
	logic [ledsu_pkg::SUM_WIDTH-1:0]   square_acc;
	logic [ledsu_pkg::TOTAL_WIDTH-1:0] series_sum;
	logic                              sat_flag;

	initial begin
		fail_count = 0;
		square_acc = '0;
		series_sum = '0;
		sat_flag = 1'b0;
	end

	assign pending = expected_points.size();

	function automatic logic [31:0] floor_sqrt64(input logic [63:0] x);
		logic [31:0] r;
		logic [31:0] t;
		r = '0;
		for (int i = 31; i >= 0; i--) begin
			t = r | (32'd1 << i);
			if (64'(t) * 64'(t) <= x)
				r = t;
		end
		return r;
	endfunction

	function automatic longint widen(input logic [31:0] raw);
		logic [63:0] t;
		t = {32'b0, raw} << (64 - VALUE_WIDTH);
		return $signed(t) >>> (64 - VALUE_WIDTH);
	endfunction

	task automatic absorb_pair(input logic [31:0] a, input logic [31:0] b,
			input logic pe, input logic se);
		longint diff;
		logic [63:0] mag;
		logic [63:0] sq;
		logic [64:0] s65;
		logic [48:0] t49;
		point_result_t res;
		diff = widen(a) - widen(b);
		mag = (diff < 0) ? -diff : diff;
		sq = mag * mag;
		s65 = {1'b0, square_acc} + {1'b0, sq};
		if (s65[64]) begin
			square_acc = ledsu_pkg::SUM_MAX;
			sat_flag = 1'b1;
		end else begin
			square_acc = s65[63:0];
		end
		if (!pe)
			return;
		res.distance = floor_sqrt64(square_acc);
		t49 = {1'b0, series_sum} + 49'(res.distance);
		if (t49[48]) begin
			series_sum = ledsu_pkg::TOTAL_MAX;
			sat_flag = 1'b1;
		end else begin
			series_sum = t49[47:0];
		end
		res.total = series_sum;
		res.last = se;
		res.ovf = sat_flag;
		expected_points.insert(expected_points.size(), res);
		square_acc = '0;
		if (se) begin
			series_sum = '0;
			sat_flag = 1'b0;
		end
	endtask

	always @(posedge clk) begin
		point_result_t exp_r;
		if (arst_n) begin
			if (push && !full)
				absorb_pair(first_value, second_value, point_end, series_end);
			if (pop && !empty) begin
				if (expected_points.size() == 0) begin
					$display("%0t: result with nothing expected, distance %h total %h",
						$time, point_distance, running_total);
					fail_count++;
				end else begin
					exp_r = expected_points.pop_front();
					if (point_distance !== exp_r.distance) begin
						$display("%0t: point_distance expected %h actual %h",
							$time, exp_r.distance, point_distance);
						fail_count++;
					end
					if (running_total !== exp_r.total) begin
						$display("%0t: running_total expected %h actual %h",
							$time, exp_r.total, running_total);
						fail_count++;
					end
					if (series_last !== exp_r.last) begin
						$display("%0t: series_last expected %b actual %b",
							$time, exp_r.last, series_last);
						fail_count++;
					end
					if (overflow !== exp_r.ovf) begin
						$display("%0t: overflow expected %b actual %b",
							$time, exp_r.ovf, overflow);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;

	localparam int RUN_LIMIT = 300000;
	localparam int HOLD_CYCLES = 500;
	localparam int RANDOM_ITEMS = 750;
	localparam int QUIET_FROM = 650;
	localparam logic [31:0] POS_MAX = 32'h7fffffff;
	localparam logic [31:0] NEG_MIN = 32'h80000000;
	localparam logic [31:0] ONE_Q16 = 32'h00010000;

	logic                                  clk = 1'b0;
	logic                                  arst_n = 1'b0;
	logic [31:0]                           first_value = '0;
	logic [31:0]                           second_value = '0;
	logic                                  point_end = 1'b0;
	logic                                  series_end = 1'b0;
	logic                                  push = 1'b0;
	logic                                  pop = 1'b0;
	logic                                  full;
	logic                                  empty;
	logic [ledsu_pkg::DIST_WIDTH-1:0]      point_distance;
	logic [ledsu_pkg::TOTAL_WIDTH-1:0]     running_total;
	logic                                  series_last;
	logic                                  overflow;
	int                                    errors;
	int                                    pending;
	int                                    cycle_cnt = 0;
	int                                    idle_pct = 0;
	bit                                    quiet = 1'b0;
	bit                                    hold_req = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	lockstep_euclidean_distance_sum_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.first_value(first_value),
		.second_value(second_value),
		.point_end(point_end),
		.series_end(series_end),
		.push(push),
		.full(full),
		.point_distance(point_distance),
		.running_total(running_total),
		.series_last(series_last),
		.overflow(overflow),
		.empty(empty),
		.pop(pop)
	);

	distance_sum_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.first_value(first_value),
		.second_value(second_value),
		.point_end(point_end),
		.series_end(series_end),
		.push(push),
		.full(full),
		.point_distance(point_distance),
		.running_total(running_total),
		.series_last(series_last),
		.overflow(overflow),
		.empty(empty),
		.pop(pop),
		.fail_count(errors),
		.pending(pending)
	);

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == RUN_LIMIT) begin
			$display("lockstep_euclidean_distance_sum_unit test failed");
			$finish;
		end
	end

	task automatic offer_pair(input logic [31:0] a, input logic [31:0] b,
			input logic pe, input logic se);
		int gap;
		if ($urandom_range(0, 99) < idle_pct) begin
			push <= 1'b0;
			gap = $urandom_range(1, 12);
			repeat (gap) @(posedge clk);
		end
		first_value <= a;
		second_value <= b;
		point_end <= pe;
		series_end <= se;
		push <= 1'b1;
		do @(posedge clk); while (full);
	endtask

	function automatic logic [31:0] pick_value();
		int sel;
		logic [31:0] v;
		sel = $urandom_range(0, 9);
		if (sel < 4) begin
			v = $urandom;
		end else if (sel < 7) begin
			v = $urandom_range(0, 1 << 20);
			if ($urandom_range(0, 1))
				v = -v;
		end else begin
			case ($urandom_range(0, 4))
				0: v = POS_MAX;
				1: v = NEG_MIN;
				2: v = '0;
				3: v = '1;
				default: v = ONE_Q16;
			endcase
		end
		return v;
	endfunction

	// receiver: random stalls, one long hold on request
	initial begin
		wait (arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				pop <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		int items;
		int n_pts;
		int n_attrs;
		logic pe;
		logic se;
		items = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		idle_pct = 20;

		offer_pair('0, '0, 1'b1, 1'b0);
		offer_pair(POS_MAX, NEG_MIN, 1'b1, 1'b0);
		offer_pair(NEG_MIN, POS_MAX, 1'b1, 1'b1);
		offer_pair(POS_MAX, POS_MAX, 1'b1, 1'b0);
		offer_pair(NEG_MIN, NEG_MIN, 1'b1, 1'b0);
		offer_pair('1, '0, 1'b1, 1'b1);
		// saturate the square sum within one point
		offer_pair(POS_MAX, NEG_MIN, 1'b0, 1'b0);
		offer_pair(NEG_MIN, POS_MAX, 1'b0, 1'b0);
		offer_pair(ONE_Q16, '0, 1'b1, 1'b0);
		offer_pair('0, ONE_Q16, 1'b1, 1'b1);
		// series end without point end is ignored
		offer_pair(3 * ONE_Q16, '0, 1'b0, 1'b1);
		offer_pair('0, 4 * ONE_Q16, 1'b1, 1'b0);
		offer_pair(32'h00000001, '0, 1'b0, 1'b0);
		offer_pair('0, 32'h00000001, 1'b1, 1'b1);
		offer_pair(32'haaaaaaaa, 32'h55555555, 1'b1, 1'b0);
		offer_pair(32'h55555555, 32'haaaaaaaa, 1'b1, 1'b1);

		while (items < RANDOM_ITEMS) begin
			idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);
			if (items >= QUIET_FROM) begin
				quiet = 1'b1;
				idle_pct = 0;
			end
			n_pts = $urandom_range(1, 5);
			for (int p = 0; p < n_pts; p++) begin
				n_attrs = $urandom_range(1, 6);
				for (int k = 0; k < n_attrs; k++) begin
					pe = (k == n_attrs - 1);
					if (pe)
						se = (p == n_pts - 1) && ($urandom_range(0, 9) != 0);
					else
						se = ($urandom_range(0, 15) == 0);
					offer_pair(pick_value(), pick_value(), pe, se);
					items++;
					if (items == 300)
						hold_req = 1'b1;
				end
			end
		end
		push <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (errors == 0)
			$display("lockstep_euclidean_distance_sum_unit test passed");
		else
			$display("lockstep_euclidean_distance_sum_unit test failed");
		$finish;
	end

endmodule
